@@ rtl/round_robin_thread_scheduler_assert.svh @@
// assertion macros for the scheduler top level
`ifndef ROUND_ROBIN_THREAD_SCHEDULER_ASSERT_SVH
`define ROUND_ROBIN_THREAD_SCHEDULER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define RRTS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define RRTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/rrts_pkg.sv @@
package rrts_pkg;

    localparam int MAX_SLOTS = 64;
    localparam int IDX_W     = 6;
    localparam int ID_W      = 32;

    typedef enum logic [1:0] {
        REQ_ALLOC = 2'd0,
        REQ_TICK  = 2'd1,
        REQ_SLEEP = 2'd2,
        REQ_EXIT  = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        ST_UNUSED   = 3'd0,
        ST_READY    = 3'd1,
        ST_RUNNING  = 3'd2,
        ST_SLEEPING = 3'd3,
        ST_ZOMBIE   = 3'd4
    } t_slot_st;

    typedef enum logic [1:0] {
        STS_OK      = 2'd0,
        STS_NO_SLOT = 2'd1,
        STS_HALTED  = 2'd2
    } t_status;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic prep;
        logic wake;
        logic sel;
        logic load;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        t_req req;
        logic halted;
        logic out_free;
    } t_sts;

    // lowest set bit: {found, index}
    function automatic logic [IDX_W:0] f_lowest(input logic [MAX_SLOTS-1:0] v);
        logic [IDX_W:0] r;
        r = '0;
        for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
            if (v[i]) begin
                r = {1'b1, IDX_W'(i)};
            end
        end
        return r;
    endfunction

endpackage

@@ rtl/round_robin_thread_scheduler.sv @@
// an accepted request runs prepare, then wake (tick, sleep) and select (tick, sleep, exit), then push;
// alloc and halted requests go from prepare straight to push, which waits for a free output register
// the prepare, wake and select passes over the slot table run in turn, so a new request is taken
// only after push; a waiting result sits in the output register while the next item is taken
// reset: synchronous, active low; slot 0 running, others unused, ids start at 1
module round_robin_thread_scheduler
    import rrts_pkg::*;
#(
    parameter int NUM_SLOTS  = 64,
    parameter int TICK_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [71:0] i_s_tdata,   // req_type[1:0], now_tick[33:2], sleep_ticks[65:34], zero pad
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata    // status[1:0], running_slot[7:2], switched[8],
                                     // new_slot[14:9], new_id[46:15], zero pad
);

    `include "round_robin_thread_scheduler_assert.svh"

    t_cmd             w_cmd;
    t_sts             w_sts;
    logic [1:0]       w_status;
    logic [IDX_W-1:0] w_running;
    logic             w_switched;
    logic [IDX_W-1:0] w_new_slot;
    logic [ID_W-1:0]  w_new_id;

    // request sequencing
    rrts_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    // slot table, wake compare, round-robin pick, result and output registers
    rrts_dp #(
        .NUM_SLOTS  (NUM_SLOTS),
        .TICK_WIDTH (TICK_WIDTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .i_req      (i_s_tdata[1:0]),
        .i_now      (i_s_tdata[33:2]),
        .i_dur      (i_s_tdata[65:34]),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_status   (w_status),
        .o_running  (w_running),
        .o_switched (w_switched),
        .o_new_slot (w_new_slot),
        .o_new_id   (w_new_id)
    );

    // pack result fields, lowest first
    assign o_m_tdata = {1'b0, w_new_id, w_new_slot, w_switched, w_running, w_status};

    // a result is never loaded over one the sink has not yet taken
    `RRTS_ASSERT_NOW(a_no_overwrite, i_clk, i_rst_n, w_cmd.load,
                     !o_m_tvalid || i_m_tready, "result overwritten")

    // once halted, the scheduler stays halted until reset
    `RRTS_ASSERT_NEXT(a_halt_sticky, i_clk, i_rst_n, w_sts.halted,
                      w_sts.halted, "halt flag dropped")

    // every accepted item starts its prepare pass in the next cycle
    `RRTS_ASSERT_NEXT(a_accept_prep, i_clk, i_rst_n, i_s_tvalid && o_s_tready,
                      w_cmd.prep && !o_s_tready, "accepted item not started")

endmodule

@@ rtl/rrts_ctrl.sv @@
module rrts_ctrl
    import rrts_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_PREP = 5'b00010,
        S_WAKE = 5'b00100,
        S_SEL  = 5'b01000,
        S_PUSH = 5'b10000
    } t_fsm;

    t_fsm r_state;
    t_fsm n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                if (i_sts.halted || i_sts.req == REQ_ALLOC) begin
                    n_state = S_PUSH;
                end else if (i_sts.req == REQ_EXIT) begin
                    n_state = S_SEL;
                end else begin
                    n_state = S_WAKE;
                end
            end
            S_WAKE: n_state = S_SEL;
            S_SEL:  n_state = S_PUSH;
            S_PUSH: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_ready      = (r_state == S_IDLE);
    assign o_cmd.accept = (r_state == S_IDLE) && i_valid;
    assign o_cmd.prep   = (r_state == S_PREP);
    assign o_cmd.wake   = (r_state == S_WAKE);
    assign o_cmd.sel    = (r_state == S_SEL);
    assign o_cmd.load   = (r_state == S_PUSH) && i_sts.out_free;

endmodule

@@ rtl/rrts_dp.sv @@
module rrts_dp
    import rrts_pkg::*;
#(
    parameter int NUM_SLOTS  = 64,
    parameter int TICK_WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    output t_sts             o_sts,
    input  logic [1:0]       i_req,
    input  logic [31:0]      i_now,
    input  logic [31:0]      i_dur,
    input  logic             i_m_tready,
    output logic             o_m_tvalid,
    output logic [1:0]       o_status,
    output logic [IDX_W-1:0] o_running,
    output logic             o_switched,
    output logic [IDX_W-1:0] o_new_slot,
    output logic [ID_W-1:0]  o_new_id
);

    localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    // slot table, one cell per slot with its own wake comparator
    t_slot_st              r_st   [NUM_SLOTS];
    logic [TICK_WIDTH-1:0] r_wake [NUM_SLOTS];

    logic [SW-1:0]         r_cur;
    logic [ID_W-1:0]       r_next_id;
    logic                  r_halt;

    t_req                  r_req;
    logic [TICK_WIDTH-1:0] r_now;
    logic [TICK_WIDTH-1:0] r_dur;

    t_status               r_res_status;
    logic                  r_res_sw;
    logic [IDX_W-1:0]      r_res_nslot;
    logic [ID_W-1:0]       r_res_nid;

    logic                  r_out_valid;
    logic [1:0]            r_out_status;
    logic [IDX_W-1:0]      r_out_running;
    logic                  r_out_sw;
    logic [IDX_W-1:0]      r_out_nslot;
    logic [ID_W-1:0]       r_out_nid;

    logic [NUM_SLOTS-1:0]  w_ready;
    logic [NUM_SLOTS-1:0]  w_unused;
    logic [NUM_SLOTS-1:0]  w_due;
    logic [NUM_SLOTS-1:0]  w_above;
    logic [IDX_W:0]        w_free;
    logic [IDX_W:0]        w_hi;
    logic [IDX_W:0]        w_lo;
    logic [SW-1:0]         w_free_idx;
    logic [SW-1:0]         w_pick;
    logic [SW-1:0]         w_tgt;
    logic                  w_halt_now;
    logic                  w_do_switch;
    t_slot_st              w_cur_st;
    logic [TICK_WIDTH:0]   w_sum;
    logic [TICK_WIDTH-1:0] w_sat;
    logic                  w_out_free;

    always_comb begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
            w_ready[i]  = (r_st[i] == ST_READY);
            w_unused[i] = (r_st[i] == ST_UNUSED);
            w_due[i]    = (r_st[i] == ST_SLEEPING) && (r_now >= r_wake[i]);
            w_above[i]  = (SW'(i) > r_cur);
        end
    end

    assign w_cur_st   = r_st[r_cur];
    assign w_free     = f_lowest(MAX_SLOTS'(w_unused));
    assign w_hi       = f_lowest(MAX_SLOTS'(w_ready & w_above));
    assign w_lo       = f_lowest(MAX_SLOTS'(w_ready));
    assign w_free_idx = SW'(w_free[IDX_W-1:0]);

    // round robin: first ready above the current slot, else wrap to the lowest
    always_comb begin
        if (w_hi[IDX_W]) begin
            w_pick = SW'(w_hi[IDX_W-1:0]);
        end else if (w_lo[IDX_W]) begin
            w_pick = SW'(w_lo[IDX_W-1:0]);
        end else begin
            w_pick = r_cur;
        end
    end

    // exit with nothing ready falls back to slot 0, halts if that is a zombie
    always_comb begin
        w_tgt      = w_pick;
        w_halt_now = 1'b0;
        if (r_req == REQ_EXIT && w_pick == r_cur) begin
            w_tgt      = '0;
            w_halt_now = (r_st[0] == ST_ZOMBIE);
        end
    end

    assign w_do_switch = !r_halt && !w_halt_now && (w_tgt != r_cur);

    // saturating wake tick
    assign w_sum = {1'b0, r_now} + {1'b0, r_dur};
    assign w_sat = w_sum[TICK_WIDTH] ? '1 : w_sum[TICK_WIDTH-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_req <= t_req'(i_req);
            r_now <= TICK_WIDTH'(i_now);
            r_dur <= TICK_WIDTH'(i_dur);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r_st[i] <= (i == 0) ? ST_RUNNING : ST_UNUSED;
            end
        end else begin
            if (i_cmd.prep && !r_halt) begin
                case (r_req)
                    REQ_ALLOC: begin
                        if (w_free[IDX_W]) begin
                            r_st[w_free_idx] <= ST_READY;
                        end
                    end
                    REQ_SLEEP: r_st[r_cur] <= ST_SLEEPING;
                    REQ_EXIT:  r_st[r_cur] <= ST_ZOMBIE;
                    default: ;
                endcase
            end
            if (i_cmd.wake) begin
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if (w_due[i]) begin
                        r_st[i] <= ST_READY;
                    end
                end
            end
            if (i_cmd.sel && w_do_switch) begin
                if (w_cur_st == ST_RUNNING) begin
                    r_st[r_cur] <= ST_READY;
                end
                r_st[w_tgt] <= ST_RUNNING;
            end
        end
    end

    // wake ticks are read only for sleeping slots, which always wrote theirs
    always_ff @(posedge i_clk) begin
        if (i_cmd.prep && !r_halt && r_req == REQ_SLEEP) begin
            r_wake[r_cur] <= w_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur     <= '0;
            r_next_id <= ID_W'(1);
            r_halt    <= 1'b0;
        end else begin
            if (i_cmd.prep && !r_halt && r_req == REQ_ALLOC && w_free[IDX_W]) begin
                r_next_id <= r_next_id + ID_W'(1);
            end
            if (i_cmd.sel && w_do_switch) begin
                r_cur <= w_tgt;
            end
            if (i_cmd.sel && !r_halt && w_halt_now) begin
                r_halt <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.prep) begin
            r_res_status <= STS_OK;
            r_res_sw     <= 1'b0;
            r_res_nslot  <= '0;
            r_res_nid    <= '0;
            if (r_halt) begin
                r_res_status <= STS_HALTED;
            end else if (r_req == REQ_ALLOC) begin
                if (w_free[IDX_W]) begin
                    r_res_nslot <= w_free[IDX_W-1:0];
                    r_res_nid   <= r_next_id;
                end else begin
                    r_res_status <= STS_NO_SLOT;
                end
            end
        end
        if (i_cmd.sel) begin
            r_res_sw <= w_do_switch;
            if (w_halt_now) begin
                r_res_status <= STS_HALTED;
            end
        end
    end

    assign w_out_free = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out_status  <= r_res_status;
            r_out_running <= IDX_W'(r_cur);
            r_out_sw      <= r_res_sw;
            r_out_nslot   <= r_res_nslot;
            r_out_nid     <= r_res_nid;
        end
    end

    assign o_sts.req      = r_req;
    assign o_sts.halted   = r_halt;
    assign o_sts.out_free = w_out_free;

    assign o_m_tvalid = r_out_valid;
    assign o_status   = r_out_status;
    assign o_running  = r_out_running;
    assign o_switched = r_out_sw;
    assign o_new_slot = r_out_nslot;
    assign o_new_id   = r_out_nid;

endmodule

@@ tb/round_robin_thread_scheduler_checker.sv @@
`timescale 1ns / 100ps

// watches both channels, predicts every scheduler answer and compares it
module round_robin_thread_scheduler_checker
    import rrts_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [71:0] i_s_tdata,   // req_type[1:0], now_tick[33:2], sleep_ticks[65:34], zero pad
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [47:0] i_m_tdata,   // status[1:0], running_slot[7:2], switched[8],
                                     // new_slot[14:9], new_id[46:15], zero pad
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked,
    output int          o_no_slot,
    output int          o_halted
);

    typedef struct packed {
        t_status           status;
        logic [IDX_W-1:0]  run_slot;
        logic              switched;
        logic [IDX_W-1:0]  new_slot;
        logic [ID_W-1:0]   new_id;
    } t_sched_answer;

    // own copy of the scheduler state
    t_slot_st          slot_st [MAX_SLOTS];
    logic [31:0]       wake_at [MAX_SLOTS];
    logic [IDX_W-1:0]  cur_slot;
    logic [ID_W-1:0]   id_ctr;
    bit                halted;

    t_sched_answer     answers_due [$];

    // round-robin search for the next ready slot after the current one
    function automatic logic [IDX_W-1:0] next_ready_slot();
        logic [IDX_W-1:0] idx;
        for (int off = 1; off < MAX_SLOTS; off++) begin
            idx = cur_slot + IDX_W'(off);
            if (slot_st[idx] == ST_READY) return idx;
        end
        return cur_slot;
    endfunction

    function automatic logic switch_slot(input logic [IDX_W-1:0] tgt);
        if (tgt == cur_slot) return 1'b0;
        if (slot_st[cur_slot] == ST_RUNNING) slot_st[cur_slot] = ST_READY;
        slot_st[tgt] = ST_RUNNING;
        cur_slot = tgt;
        return 1'b1;
    endfunction

    function automatic t_sched_answer schedule_request(input t_req req, input logic [31:0] now,
                                                       input logic [31:0] dur);
        t_sched_answer     r;
        logic [32:0]       sum;
        logic [IDX_W-1:0]  tgt;
        bit                found;
        r.status   = STS_OK;
        r.switched = 1'b0;
        r.new_slot = '0;
        r.new_id   = '0;
        found      = 1'b0;
        if (halted) begin
            r.status = STS_HALTED;
        end else begin
            case (req)
                REQ_ALLOC: begin
                    r.status = STS_NO_SLOT;
                    for (int i = 0; i < MAX_SLOTS; i++) begin
                        if (!found && slot_st[i] == ST_UNUSED) begin
                            found      = 1'b1;
                            slot_st[i] = ST_READY;
                            wake_at[i] = '0;
                            r.new_slot = IDX_W'(i);
                            r.new_id   = id_ctr;
                            id_ctr     = id_ctr + 1'b1;
                            r.status   = STS_OK;
                        end
                    end
                end
                REQ_TICK, REQ_SLEEP: begin
                    if (req == REQ_SLEEP) begin
                        // wake tick saturates instead of wrapping
                        sum = {1'b0, now} + {1'b0, dur};
                        wake_at[cur_slot] = sum[32] ? '1 : sum[31:0];
                        slot_st[cur_slot] = ST_SLEEPING;
                    end
                    for (int i = 0; i < MAX_SLOTS; i++) begin
                        if (slot_st[i] == ST_SLEEPING && now >= wake_at[i]) slot_st[i] = ST_READY;
                    end
                    r.switched = switch_slot(next_ready_slot());
                end
                default: begin
                    slot_st[cur_slot] = ST_ZOMBIE;
                    tgt = next_ready_slot();
                    if (tgt == cur_slot) begin
                        // nothing ready: fall back to slot 0 unless it is gone too
                        tgt = '0;
                        if (slot_st[0] == ST_ZOMBIE) begin
                            halted   = 1'b1;
                            r.status = STS_HALTED;
                        end
                    end
                    if (!halted) r.switched = switch_slot(tgt);
                end
            endcase
        end
        r.run_slot = cur_slot;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_sched_answer want;
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_SLOTS; i++) begin
                slot_st[i] = ST_UNUSED;
                wake_at[i] = '0;
            end
            slot_st[0] = ST_RUNNING;
            cur_slot   = '0;
            id_ctr     = 1;
            halted     = 1'b0;
            answers_due.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                o_checked++;
                if (answers_due.size() == 0) begin
                    $error("answer with no request outstanding: tdata %h", i_m_tdata);
                    o_fail_count++;
                end else begin
                    want = answers_due.pop_front();
                    if (want.status == STS_NO_SLOT) o_no_slot++;
                    if (want.status == STS_HALTED) o_halted++;
                    check_field("status", 32'(want.status), 32'(i_m_tdata[1:0]));
                    check_field("running_slot", 32'(want.run_slot), 32'(i_m_tdata[7:2]));
                    check_field("switched", 32'(want.switched), 32'(i_m_tdata[8]));
                    check_field("new_slot", 32'(want.new_slot), 32'(i_m_tdata[14:9]));
                    check_field("new_id", want.new_id, i_m_tdata[46:15]);
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                answers_due.push_back(schedule_request(t_req'(i_s_tdata[1:0]),
                                                       i_s_tdata[33:2], i_s_tdata[65:34]));
            end
        end
        o_pending = answers_due.size();
    end

endmodule

@@ tb/round_robin_thread_scheduler_test.sv @@
`timescale 1ns / 100ps

module round_robin_thread_scheduler_test;
    import rrts_pkg::*;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [71:0] i_s_tdata  = '0;   // req_type[1:0], now_tick[33:2], sleep_ticks[65:34], zero pad
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [47:0] o_m_tdata;         // status[1:0], running_slot[7:2], switched[8],
                                    // new_slot[14:9], new_id[46:15], zero pad

    int          fail_count;
    int          pending;
    int          checked;
    int          no_slot_seen;
    int          halted_seen;

    int          sent [4] = '{0, 0, 0, 0};   // items sent per request kind
    bit          idle_on = 1'b0;             // random gaps on both sides
    int          stall_left = 0;
    logic [31:0] tick_clock = '0;            // well-behaved timer for most requests

    round_robin_thread_scheduler dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    round_robin_thread_scheduler_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_no_slot    (no_slot_seen),
        .o_halted     (halted_seen)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // result side: random stall bursts while idling is on
    always @(posedge i_clk) begin
        if (!idle_on) begin
            stall_left <= 0;
            i_m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_m_tready <= 1'b0;
        end else if ($urandom_range(0, 11) == 0) begin
            stall_left <= $urandom_range(0, 18);
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // one request item; tready is sampled mid-cycle, the item moves at the next edge
    task automatic send_req(input t_req req, input logic [31:0] now, input logic [31:0] dur);
        bit took;
        if (idle_on && $urandom_range(0, 7) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {6'b0, dur, now, req};
        sent[int'(req)]++;
        do begin
            @(negedge i_clk);
            took = o_s_tready;
            @(posedge i_clk);
        end while (!took);
    endtask

    // mostly a rising timer with short sleeps, sometimes arbitrary ticks
    task automatic send_random_req();
        int          roll;
        t_req        req;
        logic [31:0] now;
        logic [31:0] dur;
        roll = $urandom_range(0, 99);
        if (roll < 14)      req = REQ_ALLOC;
        else if (roll < 58) req = REQ_TICK;
        else if (roll < 97) req = REQ_SLEEP;
        else                req = REQ_EXIT;
        if ($urandom_range(0, 15) == 0) begin
            now = $urandom;
            case ($urandom_range(0, 2))
                0:       dur = '0;
                1:       dur = '1;
                default: dur = $urandom;
            endcase
        end else begin
            tick_clock = tick_clock + $urandom_range(0, 16);
            now = tick_clock;
            dur = $urandom_range(0, 48);
        end
        send_req(req, now, dur);
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        idle_on <= 1'b1;

        // directed opening: alone on slot 0, allocs, sleeps and exits
        send_req(REQ_TICK,  32'd0, 32'd0);                       // nothing else ready
        send_req(REQ_ALLOC, '1, '1);
        send_req(REQ_ALLOC, 32'd0, 32'd0);
        send_req(REQ_SLEEP, 32'd100, '1);                        // wake tick saturates
        send_req(REQ_TICK,  '1, 32'd0);                          // wakes the saturated sleeper
        send_req(REQ_EXIT,  32'd0, 32'd0);
        send_req(REQ_SLEEP, 32'd10, 32'd5);
        send_req(REQ_SLEEP, 32'd11, 32'd100);                    // keeps a sleeping current slot
        send_req(REQ_EXIT,  32'd12, 32'd0);                      // falls back to sleeping slot 0
        send_req(REQ_SLEEP, 32'hFFFF_FFFE, 32'd1);               // sum just fits
        send_req(REQ_ALLOC, 32'd20, 32'd0);
        send_req(REQ_TICK,  32'd20, 32'd0);
        send_req(REQ_SLEEP, 32'd20, 32'd0);                      // wakes at once, stays current
        send_req(REQ_TICK,  '1, 32'd0);
        send_req(REQ_SLEEP, 32'hF000_0000, 32'h2000_0000);       // carry out saturates
        send_req(REQ_ALLOC, 32'd25, 32'h5555_5555);
        send_req(REQ_EXIT,  32'd25, 32'hAAAA_AAAA);
        send_req(REQ_TICK,  32'd30, 32'd0);
        tick_clock = 32'd40;

        // random phases, some without any gaps
        for (int phase = 0; phase < 13; phase++) begin
            idle_on <= ($urandom_range(0, 3) != 0);
            repeat (100) send_random_req();
        end

        // final stretch at full rate, then exits until no slot is ready, slot 0 is gone and the block halts
        idle_on <= 1'b0;
        repeat (60) send_random_req();
        repeat (66) send_req(REQ_EXIT, tick_clock, 32'd0);
        send_req(REQ_ALLOC, tick_clock, 32'd0);
        send_req(REQ_TICK,  '1, 32'd0);
        send_req(REQ_SLEEP, tick_clock, '1);
        send_req(REQ_EXIT,  32'd0, 32'd0);
        i_s_tvalid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("requests sent: %0d alloc, %0d tick, %0d sleep, %0d exit",
                 sent[REQ_ALLOC], sent[REQ_TICK], sent[REQ_SLEEP], sent[REQ_EXIT]);
        $display("answers checked: %0d, of them %0d refused allocs and %0d while halted",
                 checked, no_slot_seen, halted_seen);
        if (fail_count == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // hard stop well beyond the slowest legal run
    initial begin
        #10_000_000;
        $display("timeout with %0d answers outstanding", pending);
        $display("== FAIL ==");
        $finish;
    end

endmodule
